/* sv/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Request and result types, register map, status codes and the control and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam logic [1:0] CMD_ALLOC      = 2'd0;
  localparam logic [1:0] CMD_ALLOC_ZERO = 2'd1;
  localparam logic [1:0] CMD_FREE       = 2'd2;
  localparam logic [1:0] CMD_RESIZE     = 2'd3;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_UNKNOWN    = 3'd4;

  localparam logic [1:0] REG_HEADER_BYTES = 2'd0;
  localparam logic [1:0] REG_MAX_REQUEST  = 2'd1;
  localparam logic [1:0] REG_HEAP_BASE    = 2'd2;
  localparam logic [1:0] REG_HEAP_BYTES   = 2'd3;

  localparam logic [7:0]  RESET_HEADER_BYTES = 8'd32;
  localparam logic [26:0] RESET_MAX_REQUEST  = 27'd100000000;
  localparam logic [31:0] RESET_HEAP_BASE    = 32'd0;
  localparam logic [31:0] RESET_HEAP_BYTES   = 32'd1048576;

  typedef struct packed {
    logic [1:0]  command;
    logic [26:0] request_size;
    logic [26:0] element_count;
    logic [31:0] user_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_address;
    logic [31:0] copy_source;
    logic [26:0] copy_length;
    logic [26:0] zero_length;
    logic [12:0] free_block_count;
    logic [31:0] free_byte_total;
    logic [12:0] block_total;
    logic [31:0] block_byte_total;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  header_bytes;
    logic [26:0] max_request;
    logic [31:0] heap_base;
    logic [31:0] heap_bytes;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       scan_run;
    logic       scan_fit;
    logic       take;
    logic       append;
    logic       free_old;
    logic       keep;
    logic       set_status;
    logic [2:0] status;
    logic       present;
  } ctl_t;

  typedef struct packed {
    logic [1:0] command;
    logic       size_ok;
    logic       addr_zero;
    logic       scan_hit;
    logic       scan_end;
    logic       lk_free;
    logic       fits_in_place;
    logic       table_full;
    logic       heap_short;
    logic       out_busy;
  } sts_t;

endpackage

/* sv/ffba_regs.sv */
// ----------------------------------------------------------------------------
// First-fit block allocator configuration registers
// APB-style register file holding header size, request limit and heap bounds.
// ----------------------------------------------------------------------------
module ffba_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ffba_pkg::cfg_t      cfg
);
  import ffba_pkg::*;

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_bytes <= RESET_HEADER_BYTES;
      cfg.max_request  <= RESET_MAX_REQUEST;
      cfg.heap_base    <= RESET_HEAP_BASE;
      cfg.heap_bytes   <= RESET_HEAP_BYTES;
    end else if (wr_en) begin
      case (reg_index)
        REG_HEADER_BYTES: cfg.header_bytes <= pwdata[7:0];
        REG_MAX_REQUEST:  cfg.max_request  <= pwdata[26:0];
        REG_HEAP_BASE:    cfg.heap_base    <= pwdata;
        REG_HEAP_BYTES:   cfg.heap_bytes   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_HEADER_BYTES: prdata = {24'd0, cfg.header_bytes};
      REG_MAX_REQUEST:  prdata = {5'd0, cfg.max_request};
      REG_HEAP_BASE:    prdata = cfg.heap_base;
      REG_HEAP_BYTES:   prdata = cfg.heap_bytes;
      default:          prdata = '0;
    endcase
  end

endmodule

/* sv/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// First-fit block allocator controller
// Sequences size check, table lookup, first-fit search, table updates and
// result delivery for one request at a time.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::ctl_t ctl
);
  import ffba_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_MUL     = 9'b000000010,
    S_CHECK   = 9'b000000100,
    S_LOOK    = 9'b000001000,
    S_DECIDE  = 9'b000010000,
    S_FIT     = 9'b000100000,
    S_ALLOC   = 9'b001000000,
    S_RELEASE = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   moving;

  assign req_stall = (state != S_IDLE);
  assign moving    = (sts.command == CMD_RESIZE) && !sts.addr_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.status = ST_DONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.command == CMD_FREE) begin
          if (sts.addr_zero) begin
            state_next = S_DONE;
          end else begin
            ctl.scan_start = 1'b1;
            state_next     = S_LOOK;
          end
        end else if (!sts.size_ok) begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_BAD_SIZE;
          state_next     = S_DONE;
        end else if (moving) begin
          ctl.scan_start = 1'b1;
          state_next     = S_LOOK;
        end else begin
          ctl.scan_start = 1'b1;
          state_next     = S_FIT;
        end
      end
      S_LOOK: begin
        ctl.scan_run = 1'b1;
        if (sts.scan_hit) begin
          state_next = S_DECIDE;
        end else if (sts.scan_end) begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_UNKNOWN;
          state_next     = S_DONE;
        end
      end
      S_DECIDE: begin
        if (sts.command == CMD_FREE) begin
          ctl.free_old = !sts.lk_free;
          state_next   = S_DONE;
        end else if (sts.lk_free) begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_UNKNOWN;
          state_next     = S_DONE;
        end else if (sts.fits_in_place) begin
          ctl.keep   = 1'b1;
          state_next = S_DONE;
        end else begin
          ctl.scan_start = 1'b1;
          state_next     = S_FIT;
        end
      end
      S_FIT: begin
        ctl.scan_run = 1'b1;
        ctl.scan_fit = 1'b1;
        if (sts.scan_hit) begin
          ctl.take   = 1'b1;
          state_next = moving ? S_RELEASE : S_DONE;
        end else if (sts.scan_end) begin
          if (sts.table_full) begin
            ctl.set_status = 1'b1;
            ctl.status     = ST_TABLE_FULL;
            state_next     = S_DONE;
          end else if (sts.heap_short) begin
            ctl.set_status = 1'b1;
            ctl.status     = ST_EXHAUSTED;
            state_next     = S_DONE;
          end else begin
            state_next = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        ctl.append = 1'b1;
        state_next = moving ? S_RELEASE : S_DONE;
      end
      S_RELEASE: begin
        ctl.free_old = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          ctl.present = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/ffba_dp.sv */
// ----------------------------------------------------------------------------
// First-fit block allocator datapath
// Block table memories, table walk, size and heap checks, statistics
// counters and the result register.
// ----------------------------------------------------------------------------
module ffba_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  ffba_pkg::req_t req_data,
  input  ffba_pkg::cfg_t cfg,
  input  ffba_pkg::ctl_t ctl,
  output ffba_pkg::sts_t sts,
  input  logic           rsp_stall,
  output logic           rsp_valid,
  output ffba_pkg::rsp_t rsp_data
);
  import ffba_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [31:0] off_mem  [TABLE_DEPTH];
  logic [26:0] size_mem [TABLE_DEPTH];
  logic        free_mem [TABLE_DEPTH];

  req_t        req_r;
  logic [53:0] prod;
  logic [32:0] new_user;
  logic [31:0] heap_top;
  logic [12:0] free_blocks;
  logic [31:0] free_bytes;
  logic [12:0] created_blocks;
  logic [31:0] created_bytes;

  logic [CW-1:0] scan_ptr;
  logic          chk_vld;
  logic [IW-1:0] chk_idx;
  logic [31:0]   rd_off;
  logic [26:0]   rd_size;
  logic          rd_free;
  logic [IW-1:0] lk_idx;
  logic [26:0]   lk_size;
  logic          lk_free;

  logic [2:0]  wk_status;
  logic [31:0] wk_addr;
  logic [31:0] wk_csrc;
  logic [26:0] wk_clen;
  logic [26:0] wk_zlen;

  logic [53:0]   eff_size;
  logic [26:0]   alloc_size;
  logic [33:0]   new_end;
  logic          scan_more;
  logic          match;
  logic          issue;
  logic [IW-1:0] wr_idx;

  assign eff_size   = (req_r.command == CMD_ALLOC_ZERO) ? prod : {27'd0, req_r.request_size};
  assign alloc_size = eff_size[26:0];
  assign new_end    = {1'b0, new_user} + {7'd0, alloc_size};
  assign scan_more  = scan_ptr < created_blocks[CW-1:0];
  assign issue      = ctl.scan_run && scan_more;
  assign wr_idx     = created_blocks[IW-1:0];

  always_comb begin
    if (ctl.scan_fit) begin
      match = rd_free && (rd_size >= alloc_size);
    end else begin
      match = (cfg.heap_base + rd_off) == req_r.user_address;
    end
  end

  always_comb begin
    sts.command       = req_r.command;
    sts.size_ok       = (eff_size != '0) && (eff_size <= {27'd0, cfg.max_request});
    sts.addr_zero     = (req_r.user_address == '0);
    sts.scan_hit      = chk_vld && match;
    sts.scan_end      = !chk_vld && !scan_more;
    sts.lk_free       = lk_free;
    sts.fits_in_place = (req_r.request_size <= lk_size);
    sts.table_full    = (created_blocks >= 13'(TABLE_DEPTH));
    sts.heap_short    = (new_end > {2'd0, cfg.heap_bytes});
    sts.out_busy      = rsp_valid && rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= req_data;
    end
    prod     <= {27'd0, req_r.request_size} * {27'd0, req_r.element_count};
    new_user <= {1'b0, heap_top} + {25'd0, cfg.header_bytes};
  end

  // Table walk: one entry read per cycle into registers, compared in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr <= '0;
      chk_vld  <= 1'b0;
    end else if (ctl.scan_start) begin
      scan_ptr <= '0;
      chk_vld  <= 1'b0;
    end else if (ctl.scan_run) begin
      chk_vld <= scan_more;
      if (scan_more) begin
        scan_ptr <= scan_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      chk_idx <= scan_ptr[IW-1:0];
      rd_off  <= off_mem[scan_ptr[IW-1:0]];
      rd_size <= size_mem[scan_ptr[IW-1:0]];
      rd_free <= free_mem[scan_ptr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.append) begin
      off_mem[wr_idx]  <= new_user[31:0];
      size_mem[wr_idx] <= alloc_size;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.append) begin
      free_mem[wr_idx] <= 1'b0;
    end else if (ctl.take) begin
      free_mem[chk_idx] <= 1'b0;
    end else if (ctl.free_old) begin
      free_mem[lk_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_run && !ctl.scan_fit && sts.scan_hit) begin
      lk_idx  <= chk_idx;
      lk_size <= rd_size;
      lk_free <= rd_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_top       <= '0;
      free_blocks    <= '0;
      free_bytes     <= '0;
      created_blocks <= '0;
      created_bytes  <= '0;
    end else if (ctl.append) begin
      heap_top       <= new_end[31:0];
      created_blocks <= created_blocks + 13'd1;
      created_bytes  <= created_bytes + {5'd0, alloc_size};
    end else if (ctl.take) begin
      free_blocks <= free_blocks - 13'd1;
      free_bytes  <= free_bytes - {5'd0, rd_size};
    end else if (ctl.free_old) begin
      free_blocks <= free_blocks + 13'd1;
      free_bytes  <= free_bytes + {5'd0, lk_size};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      wk_status <= ST_DONE;
      wk_addr   <= '0;
      wk_csrc   <= '0;
      wk_clen   <= '0;
      wk_zlen   <= '0;
    end else begin
      if (ctl.set_status) begin
        wk_status <= ctl.status;
      end
      if (ctl.keep) begin
        wk_addr <= req_r.user_address;
      end
      if (ctl.take || ctl.append) begin
        wk_addr <= cfg.heap_base + (ctl.take ? rd_off : new_user[31:0]);
        wk_zlen <= (req_r.command == CMD_ALLOC_ZERO) ? alloc_size : 27'd0;
      end
      if (ctl.free_old && (req_r.command == CMD_RESIZE)) begin
        wk_csrc <= req_r.user_address;
        wk_clen <= lk_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.present) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.present) begin
      rsp_data.status           <= wk_status;
      rsp_data.result_address   <= wk_addr;
      rsp_data.copy_source      <= wk_csrc;
      rsp_data.copy_length      <= wk_clen;
      rsp_data.zero_length      <= wk_zlen;
      rsp_data.free_block_count <= free_blocks;
      rsp_data.free_byte_total  <= free_bytes;
      rsp_data.block_total      <= created_blocks;
      rsp_data.block_byte_total <= created_bytes;
    end
  end

  a_free_le_created: assert property (@(posedge clk) disable iff (rst)
    free_blocks <= created_blocks)
    else $error("more free blocks than created blocks");

  a_created_le_depth: assert property (@(posedge clk) disable iff (rst)
    created_blocks <= 13'(TABLE_DEPTH))
    else $error("block count exceeds table depth");

  a_free_bytes_le: assert property (@(posedge clk) disable iff (rst)
    free_bytes <= created_bytes)
    else $error("free bytes exceed created bytes");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    ctl.present |=> (rsp_data.status == ST_DONE) || (rsp_data.result_address == '0))
    else $error("failed request carries an address");

endmodule

/* sv/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// First-fit block allocator
// Handles one request at a time. Allocate and free walk the created blocks
// once, and a resize that moves walks them twice. The walk reads one table
// entry per cycle through the single read port of the block table. A new
// request is accepted while the previous result still waits in the output
// register.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ffba_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ffba_pkg::rsp_t rsp_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import ffba_pkg::*;

  cfg_t cfg;
  ctl_t ctl;
  sts_t sts;

  ffba_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  ffba_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cfg       (cfg),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

endmodule
